// ===== rtl/servo_frame_deframer_top_assert.svh =====
// ----------------------------------------------------------------------------
// Servo frame deframer assertion macros
// Concurrent checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SERVO_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define SERVO_FRAME_DEFRAMER_TOP_ASSERT_SVH

// same-cycle implication
`define SFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants and control/status types of the servo frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

  localparam int MAX_CHANNELS_DEF   = 16;
  localparam int FIXED_CHANNELS_DEF = 8;

  localparam logic [7:0] SYNC_FIXED_A = 8'hFF;
  localparam logic [7:0] SYNC_FIXED_B = 8'hEE;
  localparam logic [7:0] SYNC_VAR_A   = 8'hFE;
  localparam logic [7:0] SYNC_VAR_B   = 8'hEF;

  localparam logic [1:0] ST_CHANNEL = 2'd0;
  localparam logic [1:0] ST_FAIL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  typedef struct packed {
    logic start_fixed;
    logic start_var;
    logic take_payload;
    logic take_check_a;
    logic load_fail;
    logic load_empty;
    logic emit_start;
    logic rd_issue;
    logic emit_load;
  } sfd_cmd_t;

  typedef struct packed {
    logic is_ff;
    logic is_fe;
    logic is_ef;
    logic is_ee;
    logic count_bad;
    logic payload_done;
    logic check_ok;
    logic frame_empty;
    logic emit_last;
    logic out_free;
  } sfd_sts_t;

endpackage

`default_nettype wire

// ===== rtl/sfd_ram.sv =====
// ----------------------------------------------------------------------------
// sfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfd_ctrl
// Frame parse and result emission state machine.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_ctrl
  import sfd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire sfd_sts_t sts,
  output sfd_cmd_t      cmd
);

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_SYNC_FIXED = 8'b0000_0010,
    S_SYNC_VAR   = 8'b0000_0100,
    S_COUNT      = 8'b0000_1000,
    S_PAYLOAD    = 8'b0001_0000,
    S_CHECK_B    = 8'b0010_0000,
    S_READ       = 8'b0100_0000,
    S_LOAD       = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   acc;

  assign acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // hold input during the channel burst, and hold the final check byte while the output register is full
  always_comb begin
    case (state)
      S_READ, S_LOAD: in_ready = 1'b0;
      S_CHECK_B:      in_ready = sts.out_free;
      default:        in_ready = 1'b1;
    endcase
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (acc) begin
          if (sts.is_ff) begin
            state_next = S_SYNC_FIXED;
          end else if (sts.is_fe) begin
            state_next = S_SYNC_VAR;
          end
        end
      end
      S_SYNC_FIXED: begin
        if (acc) begin
          if (sts.is_ee) begin
            cmd.start_fixed = 1'b1;
            state_next      = S_PAYLOAD;
          end else if (!sts.is_ff) begin
            state_next = S_IDLE;
          end
        end
      end
      S_SYNC_VAR: begin
        if (acc) begin
          state_next = sts.is_ef ? S_COUNT : S_IDLE;
        end
      end
      S_COUNT: begin
        if (acc) begin
          if (sts.count_bad) begin
            state_next = S_IDLE;
          end else begin
            cmd.start_var = 1'b1;
            state_next    = S_PAYLOAD;
          end
        end
      end
      S_PAYLOAD: begin
        if (acc) begin
          if (sts.payload_done) begin
            cmd.take_check_a = 1'b1;
            state_next       = S_CHECK_B;
          end else begin
            cmd.take_payload = 1'b1;
          end
        end
      end
      S_CHECK_B: begin
        if (acc) begin
          if (!sts.check_ok) begin
            cmd.load_fail = 1'b1;
            state_next    = S_IDLE;
          end else if (sts.frame_empty) begin
            cmd.load_empty = 1'b1;
            state_next     = S_IDLE;
          end else begin
            cmd.emit_start = 1'b1;
            state_next     = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_LOAD;
      end
      S_LOAD: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          state_next    = sts.emit_last ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/sfd_dpath.sv =====
// ----------------------------------------------------------------------------
// sfd_dpath
// Byte decode, Fletcher-8 sums, payload store and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_dpath
  import sfd_pkg::*;
#(
  parameter int MAX_CHANNELS   = MAX_CHANNELS_DEF,
  parameter int FIXED_CHANNELS = FIXED_CHANNELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  rx_byte,
  input  wire sfd_cmd_t    cmd,
  output sfd_sts_t         sts,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [3:0]       channel_index,
  output logic [15:0]      channel_value,
  output logic             last
);

  localparam int CH_LIMIT = (MAX_CHANNELS > FIXED_CHANNELS) ? MAX_CHANNELS : FIXED_CHANNELS;
  localparam int N_W      = $clog2(CH_LIMIT + 1);
  localparam int POS_W    = N_W + 1;
  localparam int AW       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [POS_W-1:0] byte_pos;
  logic [N_W-1:0]   frame_ch;
  logic [N_W-1:0]   emit_idx;
  logic [N_W-1:0]   n_emit;
  logic [7:0]       sum_a;
  logic [7:0]       sum_b;
  logic [7:0]       sum_a_next;
  logic [7:0]       check_a;
  logic [7:0]       hi_byte;
  logic             wr_en;
  logic [15:0]      rd_data;

  assign sum_a_next = sum_a + rx_byte;
  assign n_emit     = (frame_ch > N_W'(MAX_CHANNELS)) ? N_W'(MAX_CHANNELS) : frame_ch;

  always_comb begin
    sts              = '0;
    sts.is_ff        = (rx_byte == SYNC_FIXED_A);
    sts.is_fe        = (rx_byte == SYNC_VAR_A);
    sts.is_ef        = (rx_byte == SYNC_VAR_B);
    sts.is_ee        = (rx_byte == SYNC_FIXED_B);
    sts.count_bad    = sts.is_ff || sts.is_fe || sts.is_ef
                       || (rx_byte > 8'(MAX_CHANNELS));
    sts.payload_done = (byte_pos == {frame_ch, 1'b0});
    sts.check_ok     = (check_a == sum_a) && (rx_byte == sum_b);
    sts.frame_empty  = (frame_ch == '0);
    sts.emit_last    = (({1'b0, emit_idx} + 1'b1) == {1'b0, n_emit});
    sts.out_free     = !out_valid || out_ready;
  end

  // store a word on the low byte of each channel that fits
  assign wr_en = cmd.take_payload && byte_pos[0]
                 && (byte_pos[POS_W-1:1] < N_W'(MAX_CHANNELS));

  sfd_ram #(
    .WIDTH (16),
    .DEPTH (MAX_CHANNELS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(byte_pos[POS_W-1:1])),
    .wr_data ({hi_byte, rx_byte}),
    .rd_en   (cmd.rd_issue),
    .rd_addr (AW'(emit_idx)),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos  <= '0;
      frame_ch  <= '0;
      emit_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.start_fixed) begin
        frame_ch <= N_W'(FIXED_CHANNELS);
        byte_pos <= '0;
      end else if (cmd.start_var) begin
        frame_ch <= N_W'(rx_byte);
        byte_pos <= '0;
      end else if (cmd.take_payload) begin
        byte_pos <= byte_pos + 1'b1;
      end
      if (cmd.emit_start) begin
        emit_idx <= '0;
      end else if (cmd.emit_load) begin
        emit_idx <= emit_idx + 1'b1;
      end
      if (cmd.load_fail || cmd.load_empty || cmd.emit_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_fixed || cmd.start_var) begin
      sum_a <= '0;
      sum_b <= '0;
    end else if (cmd.take_payload) begin
      sum_a <= sum_a_next;
      sum_b <= sum_b + sum_a_next;
    end
    if (cmd.take_payload && !byte_pos[0]) begin
      hi_byte <= rx_byte;
    end
    if (cmd.take_check_a) begin
      check_a <= rx_byte;
    end
    if (cmd.load_fail || cmd.load_empty) begin
      status        <= cmd.load_fail ? ST_FAIL : ST_EMPTY;
      channel_index <= '0;
      channel_value <= '0;
      last          <= 1'b1;
    end else if (cmd.emit_load) begin
      status        <= ST_CHANNEL;
      channel_index <= 4'(emit_idx);
      channel_value <= rd_data;
      last          <= sts.emit_last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/servo_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// servo_frame_deframer_top
// Parses FF EE fixed and FE EF counted servo frames with Fletcher-8 check
// bytes and emits one word per channel, or one status word per frame.
//
//   channel   handshake             payload
//   input     in_valid / in_ready   rx_byte
//   output    out_valid / out_ready status, channel_index, channel_value, last
//
// Input bytes are accepted back to back while a frame is parsed.
// After a good final check byte, each channel word takes a payload store
// read and then an output register load, which waits while the output register is full;
// input holds until the last word is loaded.
// The final check byte waits while the output register is still full.
// Synchronous reset returns the parser to idle; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "servo_frame_deframer_top_assert.svh"

module servo_frame_deframer_top
  import sfd_pkg::*;
#(
  parameter int MAX_CHANNELS   = MAX_CHANNELS_DEF,
  parameter int FIXED_CHANNELS = FIXED_CHANNELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [3:0]       channel_index,
  output logic [15:0]      channel_value,
  output logic             last
);

  sfd_cmd_t cmd;
  sfd_sts_t sts;

  sfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfd_dpath #(
    .MAX_CHANNELS   (MAX_CHANNELS),
    .FIXED_CHANNELS (FIXED_CHANNELS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .rx_byte       (rx_byte),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .last          (last)
  );

  `SFD_ASSERT_NOW(a_no_overwrite, cmd.emit_load, sts.out_free,
                  "channel word loaded over a pending word")
  `SFD_ASSERT_NOW(a_no_input_in_burst, in_valid && in_ready,
                  !(cmd.rd_issue || cmd.emit_load), "input word taken during channel burst")
  `SFD_ASSERT_NOW(a_status_last, out_valid && (status != ST_CHANNEL), last,
                  "status word without last mark")
  `SFD_ASSERT_NEXT(a_read_then_load, cmd.rd_issue, !in_ready && !cmd.rd_issue,
                   "store read not followed by load wait")

endmodule

`default_nettype wire
